// ----- src/sdr_pkg.sv -----
// shared types and constants for the shadow depth rasterizer
// item structs, sequencer codes and fixed arithmetic widths; no dependencies
package sdr_pkg;

    localparam int ACC_W  = 64;   // accumulator, depth numerator and quotient width
    localparam int EDGE_W = 44;   // edge function and triangle area width
    localparam int REM_W  = 44;   // divisor and remainder width
    localparam int MB_W   = 22;   // serial multiplier operand width
    localparam int DEP_W  = 17;   // stored biased depth width

    localparam logic [DEP_W-1:0] DEPTH_EMPTY = 17'h10000;
    localparam logic signed [ACC_W-1:0] DEPTH_BIAS = 64'sd32768;

    localparam logic [1:0] MODE_DRAW   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [19:0] v0_x;
        logic signed [19:0] v0_y;
        logic signed [15:0] v0_depth;
        logic signed [19:0] v1_x;
        logic signed [19:0] v1_y;
        logic signed [15:0] v1_depth;
        logic signed [19:0] v2_x;
        logic signed [19:0] v2_y;
        logic signed [15:0] v2_depth;
        logic signed [11:0] sample_x;
        logic signed [11:0] sample_y;
    } in_item_t;

    typedef struct packed {
        logic [16:0] read_depth;
        logic        in_map;
        logic [16:0] pixels_written;
        logic        degenerate;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic clr;
        logic sub;
    } mac_cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SAMPLE,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_SETUP,
        ST_DIV_ISSUE,
        ST_DIV_WAIT,
        ST_PIX,
        ST_PIX_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        MS_AREA_0, MS_AREA_1,
        MS_E0_0, MS_E0_1,
        MS_E1_0, MS_E1_1,
        MS_E2_0, MS_E2_1,
        MS_N_0, MS_N_1, MS_N_2,
        MS_SY_0, MS_SY_1, MS_SY_2,
        MS_SX_0, MS_SX_1, MS_SX_2
    } mul_step_t;

    typedef enum logic [1:0] {
        DS_START,
        DS_XSTEP,
        DS_YSTEP
    } div_sel_t;

endpackage

// ----- src/sdr_ram.sv -----
// generic single-write, single-read ram with registered read data
// standalone; no package needed
module sdr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sdr_mac.sv -----
// shift-add serial multiply-accumulate, one multiplier bit per cycle
// uses sdr_pkg for widths and the command struct
module sdr_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sdr_pkg::mac_cmd_t                cmd,
    input  logic signed [sdr_pkg::ACC_W-1:0] a,
    input  logic signed [sdr_pkg::MB_W-1:0]  b,
    output logic                             busy,
    output logic signed [sdr_pkg::ACC_W-1:0] acc
);

    logic [sdr_pkg::MB_W-1:0]         mplier_reg;
    logic signed [sdr_pkg::ACC_W-1:0] mcand_reg;
    logic signed [sdr_pkg::ACC_W-1:0] acc_reg;
    logic                             b_neg;

    assign b_neg = b[sdr_pkg::MB_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mplier_reg <= '0;
        end
        else if (cmd.start)
        begin
            mplier_reg <= b_neg ? sdr_pkg::MB_W'(-b) : sdr_pkg::MB_W'(b);
        end
        else if (mplier_reg != '0)
        begin
            mplier_reg <= mplier_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            // fold the sign of b and the subtract flag into the multiplicand
            mcand_reg <= (b_neg ^ cmd.sub) ? -a : a;
            if (cmd.clr)
            begin
                acc_reg <= '0;
            end
        end
        else if (mplier_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg <= mcand_reg <<< 1;
        end
    end

    assign busy = mplier_reg != '0;
    assign acc  = acc_reg;

endmodule

// ----- src/sdr_div.sv -----
// restoring divider, one quotient bit per cycle, floor quotient and nonnegative remainder
// signed dividend over a positive divisor; uses sdr_pkg for widths
module sdr_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [sdr_pkg::ACC_W-1:0] dividend,
    input  logic [sdr_pkg::REM_W-1:0]        divisor,
    output logic                             busy,
    output logic signed [sdr_pkg::ACC_W-1:0] quotient,
    output logic [sdr_pkg::REM_W-1:0]        remainder
);

    localparam int CNT_W = $clog2(sdr_pkg::ACC_W + 1);

    logic [CNT_W-1:0]          cnt_reg;
    logic                      fix_reg;
    logic                      neg_reg;
    logic [sdr_pkg::ACC_W-1:0] quo_reg;
    logic [sdr_pkg::REM_W-1:0] rem_reg;
    logic [sdr_pkg::REM_W:0]   trial;
    logic                      fits;

    assign trial = {rem_reg, quo_reg[sdr_pkg::ACC_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            fix_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(sdr_pkg::ACC_W);
            fix_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            fix_reg <= cnt_reg == CNT_W'(1);
        end
        else
        begin
            fix_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[sdr_pkg::ACC_W-1];
            quo_reg <= dividend[sdr_pkg::ACC_W-1] ? sdr_pkg::ACC_W'(-dividend)
                                                   : sdr_pkg::ACC_W'(dividend);
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[sdr_pkg::ACC_W-2:0], fits};
            rem_reg <= fits ? sdr_pkg::REM_W'(trial - {1'b0, divisor})
                            : trial[sdr_pkg::REM_W-1:0];
        end
        else if (fix_reg && neg_reg)
        begin
            // turn the magnitude result into floor division
            if (rem_reg != '0)
            begin
                quo_reg <= ~quo_reg;
                rem_reg <= divisor - rem_reg;
            end
            else
            begin
                quo_reg <= -quo_reg;
            end
        end
    end

    assign busy      = (cnt_reg != '0) || fix_reg;
    assign quotient  = $signed(quo_reg);
    assign remainder = rem_reg;

endmodule

// ----- src/shadow_depth_rasterizer.sv -----
// shadow_depth_rasterizer: depth-only triangle rasterizer with an on-chip depth store
// draw: serial setup multiplies on the mac, a setup state, three divides (start depth, x step, y step),
//   then a walk over the bounding box with a compare state for each covered pixel, then a done state;
//   a zero-area or off-map draw ends after the two area multiplies (shared mac/divider)
// sample: reads the store; clear: writes every map address; one item in flight at a time
// reset: async active low, then a clearing pass over every map address, no input taken
module shadow_depth_rasterizer #(
    parameter int MAP_WIDTH  = 256,
    parameter int MAP_HEIGHT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sdr_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output sdr_pkg::out_item_t  out_item
);

    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int XW    = $clog2(MAP_WIDTH);
    localparam int YW    = $clog2(MAP_HEIGHT);
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = sdr_pkg::EDGE_W;
    localparam int QW    = sdr_pkg::ACC_W;
    localparam int RW    = sdr_pkg::REM_W;
    localparam logic signed [13:0] XMAX = 14'(MAP_WIDTH - 1);
    localparam logic signed [13:0] YMAX = 14'(MAP_HEIGHT - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(MAP_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef struct packed {
        logic signed [QW-1:0] q;
        logic [RW-1:0]        r;
    } qr_t;

    function automatic qr_t qr_step(input qr_t cur, input qr_t inc, input logic [RW-1:0] a);
        logic [RW:0] s;
        qr_t         res;
        s = {1'b0, cur.r} + {1'b0, inc.r};
        if (s >= {1'b0, a})
        begin
            res.r = RW'(s - {1'b0, a});
            res.q = cur.q + inc.q + 64'sd1;
        end
        else
        begin
            res.r = s[RW-1:0];
            res.q = cur.q + inc.q;
        end
        return res;
    endfunction

    sdr_pkg::state_t    state_reg, state_next;
    sdr_pkg::mul_step_t step_reg;
    sdr_pkg::div_sel_t  div_sel_reg;
    logic               out_valid_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               clr_item_reg;

    sdr_pkg::in_item_t  in_reg;
    sdr_pkg::out_item_t res_reg;
    sdr_pkg::out_item_t out_item_reg;
    logic [16:0]        count_reg;

    logic [XW-1:0] minx_reg, maxx_reg, x_reg;
    logic [YW-1:0] miny_reg, maxy_reg, y_reg;
    logic          box_empty_reg;
    logic [AW-1:0] addr_reg, addr_row_reg;

    logic signed [EW-1:0] area_reg;
    logic                 area_neg_reg;
    logic [RW-1:0]        a_reg;
    logic signed [EW-1:0] e_reg [3];
    logic signed [EW-1:0] erow_reg [3];
    logic signed [QW-1:0] n_reg, sy_reg, sx_reg, dnx_reg, dny_reg;
    qr_t                  cur_reg, row_reg, qx_reg, qy_reg;

    // bounding box from the incoming item
    logic signed [19:0] mnx, mxx, mny, mxy;
    logic signed [20:0] cx, cy;
    logic signed [13:0] fx14, cx14, fy14, cy14, lox, hix, loy, hiy;
    logic               box_empty;
    logic               sample_in;
    logic [AW-1:0]      sample_addr;

    logic signed [20:0] dx [3];
    logic signed [20:0] dy [3];
    logic signed [15:0] dv [3];
    logic signed [21:0] psx, psy;
    logic signed [EW-1:0] ex_step [3];
    logic signed [EW-1:0] ey_step [3];

    sdr_pkg::mac_cmd_t    mac_cmd;
    logic signed [QW-1:0] mac_a;
    logic signed [sdr_pkg::MB_W-1:0] mac_b;
    logic                 mac_busy;
    logic signed [QW-1:0] mac_acc;
    logic                 mul_last;

    logic                 div_start;
    logic signed [QW-1:0] div_dividend;
    logic                 div_busy;
    logic signed [QW-1:0] div_q;
    logic [RW-1:0]        div_r;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    logic [sdr_pkg::DEP_W-1:0]     ram_wdata, ram_rdata;

    logic                 accept;
    logic                 out_free;
    logic                 covered;
    logic                 last_x, last_y;
    logic signed [QW-1:0] z;
    logic [sdr_pkg::DEP_W-1:0] biased;
    logic                 closer;
    logic                 advance;
    qr_t                  cur_xn, row_yn;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        mnx = in_item.v0_x;
        if (in_item.v1_x < mnx) mnx = in_item.v1_x;
        if (in_item.v2_x < mnx) mnx = in_item.v2_x;
        mxx = in_item.v0_x;
        if (in_item.v1_x > mxx) mxx = in_item.v1_x;
        if (in_item.v2_x > mxx) mxx = in_item.v2_x;
        mny = in_item.v0_y;
        if (in_item.v1_y < mny) mny = in_item.v1_y;
        if (in_item.v2_y < mny) mny = in_item.v2_y;
        mxy = in_item.v0_y;
        if (in_item.v1_y > mxy) mxy = in_item.v1_y;
        if (in_item.v2_y > mxy) mxy = in_item.v2_y;
        cx   = (21'(mxx) + 21'sd255) >>> 8;
        cy   = (21'(mxy) + 21'sd255) >>> 8;
        fx14 = 14'(mnx >>> 8);
        fy14 = 14'(mny >>> 8);
        cx14 = 14'(cx);
        cy14 = 14'(cy);
        lox  = (fx14 < 14'sd0) ? 14'sd0 : fx14;
        loy  = (fy14 < 14'sd0) ? 14'sd0 : fy14;
        hix  = (cx14 > XMAX) ? XMAX : cx14;
        hiy  = (cy14 > YMAX) ? YMAX : cy14;
        box_empty = (lox > hix) || (loy > hiy);
    end

    assign sample_in = (in_item.sample_x >= 12'sd0) && (in_item.sample_y >= 12'sd0)
                       && (14'(in_item.sample_x) <= XMAX) && (14'(in_item.sample_y) <= YMAX);
    assign sample_addr = AW'(AW'(in_item.sample_y[YW-1:0]) * ROW_STEP)
                         + AW'(in_item.sample_x[XW-1:0]);

    // edge deltas: edge 0 runs v1->v2, edge 1 v2->v0, edge 2 v0->v1
    assign dx[0] = in_reg.v2_x - in_reg.v1_x;
    assign dx[1] = in_reg.v0_x - in_reg.v2_x;
    assign dx[2] = in_reg.v1_x - in_reg.v0_x;
    assign dy[0] = in_reg.v2_y - in_reg.v1_y;
    assign dy[1] = in_reg.v0_y - in_reg.v2_y;
    assign dy[2] = in_reg.v1_y - in_reg.v0_y;
    assign dv[0] = in_reg.v0_depth;
    assign dv[1] = in_reg.v1_depth;
    assign dv[2] = in_reg.v2_depth;

    // first pixel centre of the clamped box
    assign psx = $signed(22'(minx_reg) << 8) + 22'sd128;
    assign psy = $signed(22'(miny_reg) << 8) + 22'sd128;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ex_step[i] = EW'(dy[i]) <<< 8;
            ey_step[i] = -(EW'(dx[i]) <<< 8);
        end
    end

    // operands of the current setup product
    always_comb
    begin
        mac_a    = '0;
        mac_b    = '0;
        mac_cmd  = '0;
        mul_last = 1'b0;
        case (step_reg)
            sdr_pkg::MS_AREA_0:
            begin
                mac_a = -QW'(dx[1]);
                mac_b = sdr_pkg::MB_W'(dy[2]);
                mac_cmd.clr = 1'b1;
            end
            sdr_pkg::MS_AREA_1:
            begin
                mac_a = -QW'(dy[1]);
                mac_b = sdr_pkg::MB_W'(dx[2]);
                mac_cmd.sub = 1'b1;
                mul_last = 1'b1;
            end
            sdr_pkg::MS_E0_0:
            begin
                mac_a = QW'(psx - 22'(in_reg.v1_x));
                mac_b = sdr_pkg::MB_W'(dy[0]);
                mac_cmd.clr = 1'b1;
            end
            sdr_pkg::MS_E0_1:
            begin
                mac_a = QW'(psy - 22'(in_reg.v1_y));
                mac_b = sdr_pkg::MB_W'(dx[0]);
                mac_cmd.sub = 1'b1;
                mul_last = 1'b1;
            end
            sdr_pkg::MS_E1_0:
            begin
                mac_a = QW'(psx - 22'(in_reg.v2_x));
                mac_b = sdr_pkg::MB_W'(dy[1]);
                mac_cmd.clr = 1'b1;
            end
            sdr_pkg::MS_E1_1:
            begin
                mac_a = QW'(psy - 22'(in_reg.v2_y));
                mac_b = sdr_pkg::MB_W'(dx[1]);
                mac_cmd.sub = 1'b1;
                mul_last = 1'b1;
            end
            sdr_pkg::MS_E2_0:
            begin
                mac_a = QW'(psx - 22'(in_reg.v0_x));
                mac_b = sdr_pkg::MB_W'(dy[2]);
                mac_cmd.clr = 1'b1;
            end
            sdr_pkg::MS_E2_1:
            begin
                mac_a = QW'(psy - 22'(in_reg.v0_y));
                mac_b = sdr_pkg::MB_W'(dx[2]);
                mac_cmd.sub = 1'b1;
                mul_last = 1'b1;
            end
            sdr_pkg::MS_N_0:
            begin
                mac_a = QW'(e_reg[0]);
                mac_b = sdr_pkg::MB_W'(dv[0]);
                mac_cmd.clr = 1'b1;
            end
            sdr_pkg::MS_N_1:
            begin
                mac_a = QW'(e_reg[1]);
                mac_b = sdr_pkg::MB_W'(dv[1]);
            end
            sdr_pkg::MS_N_2:
            begin
                mac_a = QW'(e_reg[2]);
                mac_b = sdr_pkg::MB_W'(dv[2]);
                mul_last = 1'b1;
            end
            sdr_pkg::MS_SY_0:
            begin
                mac_a = QW'(dy[0]);
                mac_b = sdr_pkg::MB_W'(dv[0]);
                mac_cmd.clr = 1'b1;
            end
            sdr_pkg::MS_SY_1:
            begin
                mac_a = QW'(dy[1]);
                mac_b = sdr_pkg::MB_W'(dv[1]);
            end
            sdr_pkg::MS_SY_2:
            begin
                mac_a = QW'(dy[2]);
                mac_b = sdr_pkg::MB_W'(dv[2]);
                mul_last = 1'b1;
            end
            sdr_pkg::MS_SX_0:
            begin
                mac_a = QW'(dx[0]);
                mac_b = sdr_pkg::MB_W'(dv[0]);
                mac_cmd.clr = 1'b1;
            end
            sdr_pkg::MS_SX_1:
            begin
                mac_a = QW'(dx[1]);
                mac_b = sdr_pkg::MB_W'(dv[1]);
            end
            sdr_pkg::MS_SX_2:
            begin
                mac_a = QW'(dx[2]);
                mac_b = sdr_pkg::MB_W'(dv[2]);
                mul_last = 1'b1;
            end
            default:
            begin
                mac_a = '0;
            end
        endcase
        mac_cmd.start = state_reg == sdr_pkg::ST_MUL_ISSUE;
    end

    sdr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .a     (mac_a),
        .b     (mac_b),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    always_comb
    begin
        case (div_sel_reg)
            sdr_pkg::DS_START: div_dividend = n_reg;
            sdr_pkg::DS_XSTEP: div_dividend = dnx_reg;
            sdr_pkg::DS_YSTEP: div_dividend = dny_reg;
            default:           div_dividend = n_reg;
        endcase
    end

    assign div_start = state_reg == sdr_pkg::ST_DIV_ISSUE;

    sdr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (a_reg),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // pixel walk
    assign covered = area_neg_reg
        ? (e_reg[0] <= 0) && (e_reg[1] <= 0) && (e_reg[2] <= 0)
        : (e_reg[0] >= 0) && (e_reg[1] >= 0) && (e_reg[2] >= 0);
    assign last_x  = x_reg == maxx_reg;
    assign last_y  = y_reg == maxy_reg;
    // floor quotient back to truncation toward zero
    assign z       = cur_reg.q + ((cur_reg.q < 0 && cur_reg.r != '0) ? 64'sd1 : 64'sd0);
    assign biased  = sdr_pkg::DEP_W'(z + sdr_pkg::DEPTH_BIAS);
    assign closer  = biased < ram_rdata;
    assign advance = (state_reg == sdr_pkg::ST_PIX && !covered)
                     || state_reg == sdr_pkg::ST_PIX_CMP;
    assign cur_xn  = qr_step(cur_reg, qx_reg, a_reg);
    assign row_yn  = qr_step(row_reg, qy_reg, a_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = biased;
        ram_raddr = addr_reg;
        if (state_reg == sdr_pkg::ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = sdr_pkg::DEPTH_EMPTY;
        end
        else if (state_reg == sdr_pkg::ST_PIX_CMP)
        begin
            ram_we = closer;
        end
        if (state_reg == sdr_pkg::ST_IDLE)
        begin
            ram_raddr = sample_addr;
        end
    end

    sdr_ram #(
        .WIDTH (sdr_pkg::DEP_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sdr_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = clr_item_reg ? sdr_pkg::ST_DONE : sdr_pkg::ST_IDLE;
                end
            end
            sdr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.mode)
                        sdr_pkg::MODE_DRAW:   state_next = sdr_pkg::ST_MUL_ISSUE;
                        sdr_pkg::MODE_SAMPLE: state_next = sdr_pkg::ST_SAMPLE;
                        sdr_pkg::MODE_CLEAR:  state_next = sdr_pkg::ST_CLEAR;
                        default:              state_next = sdr_pkg::ST_DONE;
                    endcase
                end
            end
            sdr_pkg::ST_SAMPLE:    state_next = sdr_pkg::ST_DONE;
            sdr_pkg::ST_MUL_ISSUE: state_next = sdr_pkg::ST_MUL_WAIT;
            sdr_pkg::ST_MUL_WAIT:
            begin
                if (!mac_busy)
                begin
                    if (step_reg == sdr_pkg::MS_AREA_1 && (mac_acc == '0 || box_empty_reg))
                    begin
                        state_next = sdr_pkg::ST_DONE;
                    end
                    else if (step_reg == sdr_pkg::MS_SX_2)
                    begin
                        state_next = sdr_pkg::ST_SETUP;
                    end
                    else
                    begin
                        state_next = sdr_pkg::ST_MUL_ISSUE;
                    end
                end
            end
            sdr_pkg::ST_SETUP:     state_next = sdr_pkg::ST_DIV_ISSUE;
            sdr_pkg::ST_DIV_ISSUE: state_next = sdr_pkg::ST_DIV_WAIT;
            sdr_pkg::ST_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = (div_sel_reg == sdr_pkg::DS_YSTEP) ? sdr_pkg::ST_PIX
                                                                   : sdr_pkg::ST_DIV_ISSUE;
                end
            end
            sdr_pkg::ST_PIX:
            begin
                if (covered)
                begin
                    state_next = sdr_pkg::ST_PIX_CMP;
                end
                else if (last_x && last_y)
                begin
                    state_next = sdr_pkg::ST_DONE;
                end
            end
            sdr_pkg::ST_PIX_CMP:
            begin
                state_next = (last_x && last_y) ? sdr_pkg::ST_DONE : sdr_pkg::ST_PIX;
            end
            sdr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = sdr_pkg::ST_IDLE;
                end
            end
            default: state_next = sdr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = state_reg != sdr_pkg::ST_IDLE;
        out_valid = out_valid_reg;
        out_item  = out_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdr_pkg::ST_CLEAR;
            step_reg      <= sdr_pkg::MS_AREA_0;
            div_sel_reg   <= sdr_pkg::DS_START;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            clr_item_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sdr_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + 1'b1;
            end
            if (accept)
            begin
                clr_item_reg <= in_item.mode == sdr_pkg::MODE_CLEAR;
                step_reg     <= sdr_pkg::MS_AREA_0;
            end
            if (state_reg == sdr_pkg::ST_MUL_WAIT && !mac_busy
                && step_reg != sdr_pkg::MS_SX_2)
            begin
                step_reg <= sdr_pkg::mul_step_t'(step_reg + 1'b1);
            end
            if (state_reg == sdr_pkg::ST_SETUP)
            begin
                div_sel_reg <= sdr_pkg::DS_START;
            end
            else if (state_reg == sdr_pkg::ST_DIV_WAIT && !div_busy)
            begin
                div_sel_reg <= (div_sel_reg == sdr_pkg::DS_START) ? sdr_pkg::DS_XSTEP
                                                                  : sdr_pkg::DS_YSTEP;
            end
            if (state_reg == sdr_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg            <= in_item;
            res_reg           <= '{read_depth: '0,
                                   in_map: (in_item.mode == sdr_pkg::MODE_SAMPLE) && sample_in,
                                   pixels_written: '0,
                                   degenerate: 1'b0};
            count_reg         <= '0;
            minx_reg          <= lox[XW-1:0];
            maxx_reg          <= hix[XW-1:0];
            miny_reg          <= loy[YW-1:0];
            maxy_reg          <= hiy[YW-1:0];
            box_empty_reg     <= box_empty;
        end

        if (state_reg == sdr_pkg::ST_SAMPLE)
        begin
            res_reg.read_depth <= res_reg.in_map ? ram_rdata : sdr_pkg::DEPTH_EMPTY;
        end

        if (state_reg == sdr_pkg::ST_MUL_WAIT && !mac_busy && mul_last)
        begin
            case (step_reg)
                sdr_pkg::MS_AREA_1:
                begin
                    area_reg           <= EW'(mac_acc);
                    res_reg.degenerate <= mac_acc == '0;
                end
                sdr_pkg::MS_E0_1: e_reg[0] <= EW'(mac_acc);
                sdr_pkg::MS_E1_1: e_reg[1] <= EW'(mac_acc);
                sdr_pkg::MS_E2_1: e_reg[2] <= EW'(mac_acc);
                sdr_pkg::MS_N_2:  n_reg    <= mac_acc;
                sdr_pkg::MS_SY_2: sy_reg   <= mac_acc;
                sdr_pkg::MS_SX_2: sx_reg   <= mac_acc;
                default:          n_reg    <= n_reg;
            endcase
        end

        if (state_reg == sdr_pkg::ST_SETUP)
        begin
            // work with a positive area so the divider sees a positive divisor
            area_neg_reg <= area_reg < 0;
            a_reg        <= (area_reg < 0) ? RW'(-area_reg) : RW'(area_reg);
            n_reg        <= (area_reg < 0) ? -n_reg : n_reg;
            dnx_reg      <= (area_reg < 0) ? -(sy_reg <<< 8) : (sy_reg <<< 8);
            dny_reg      <= (area_reg < 0) ? (sx_reg <<< 8) : -(sx_reg <<< 8);
            x_reg        <= minx_reg;
            y_reg        <= miny_reg;
            addr_reg     <= AW'(AW'(miny_reg) * ROW_STEP) + AW'(minx_reg);
            addr_row_reg <= AW'(AW'(miny_reg) * ROW_STEP) + AW'(minx_reg);
            erow_reg     <= e_reg;
        end

        if (state_reg == sdr_pkg::ST_DIV_WAIT && !div_busy)
        begin
            case (div_sel_reg)
                sdr_pkg::DS_START:
                begin
                    cur_reg.q <= div_q;
                    cur_reg.r <= div_r;
                    row_reg.q <= div_q;
                    row_reg.r <= div_r;
                end
                sdr_pkg::DS_XSTEP:
                begin
                    qx_reg.q <= div_q;
                    qx_reg.r <= div_r;
                end
                default:
                begin
                    qy_reg.q <= div_q;
                    qy_reg.r <= div_r;
                end
            endcase
        end

        if (state_reg == sdr_pkg::ST_PIX_CMP && closer)
        begin
            count_reg <= count_reg + 1'b1;
        end

        if (advance)
        begin
            if (!last_x)
            begin
                x_reg    <= x_reg + 1'b1;
                addr_reg <= addr_reg + 1'b1;
                cur_reg  <= cur_xn;
                for (int i = 0; i < 3; i++)
                begin
                    e_reg[i] <= e_reg[i] + ex_step[i];
                end
            end
            else if (!last_y)
            begin
                x_reg        <= minx_reg;
                y_reg        <= y_reg + 1'b1;
                addr_row_reg <= addr_row_reg + ROW_STEP;
                addr_reg     <= addr_row_reg + ROW_STEP;
                row_reg      <= row_yn;
                cur_reg      <= row_yn;
                for (int i = 0; i < 3; i++)
                begin
                    erow_reg[i] <= erow_reg[i] + ey_step[i];
                    e_reg[i]    <= erow_reg[i] + ey_step[i];
                end
            end
        end

        if (state_reg == sdr_pkg::ST_DONE && out_free)
        begin
            out_item_reg <= '{read_depth: res_reg.read_depth,
                              in_map: res_reg.in_map,
                              pixels_written: count_reg,
                              degenerate: res_reg.degenerate};
        end
    end

endmodule

// ----- tb/shadow_depth_rasterizer_tb.sv -----
// testbench for shadow_depth_rasterizer: directed table then random draws, samples, no-ops, clears
// predicts every result with its own depth map; depends on sdr_pkg and the rasterizer rtl
module shadow_depth_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 256;
    localparam int H = 256;
    localparam int IDLE_LIMIT = 400000;
    localparam logic [1:0] MODE_NOP = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    sdr_pkg::in_item_t in_item;
    logic out_valid;
    logic out_stall;
    sdr_pkg::out_item_t out_item;

    shadow_depth_rasterizer #(.MAP_WIDTH(W), .MAP_HEIGHT(H)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    logic [16:0] shadow_map [W*H];
    sdr_pkg::out_item_t pending_results [$];
    int errors = 0;
    int idle_cycles = 0;

    typedef struct {
        sdr_pkg::in_item_t item;
        bit has_known;
        sdr_pkg::out_item_t known;
    } dir_row_t;
    dir_row_t dir_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
        return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    endfunction

    function automatic longint floor_div256(longint v);
        return v >= 0 ? v / 256 : -((-v + 255) / 256);
    endfunction

    function automatic longint ceil_div256(longint v);
        return v >= 0 ? (v + 255) / 256 : -((-v) / 256);
    endfunction

    function automatic sdr_pkg::out_item_t rasterize_item(sdr_pkg::in_item_t it);
        sdr_pkg::out_item_t r;
        longint x0, y0, x1, y1, x2, y2, d0, d1, d2, area;
        longint minx, maxx, miny, maxy, px, py, e0, e1, e2, z;
        int cnt;
        logic [16:0] biased;
        r = '0;
        cnt = 0;
        case (it.mode)
            sdr_pkg::MODE_DRAW:
            begin
                x0 = it.v0_x; y0 = it.v0_y; d0 = it.v0_depth;
                x1 = it.v1_x; y1 = it.v1_y; d1 = it.v1_depth;
                x2 = it.v2_x; y2 = it.v2_y; d2 = it.v2_depth;
                area = edge_val(x0, y0, x1, y1, x2, y2);
                if (area == 0)
                    r.degenerate = 1'b1;
                else
                begin
                    minx = x0; if (x1 < minx) minx = x1; if (x2 < minx) minx = x2;
                    maxx = x0; if (x1 > maxx) maxx = x1; if (x2 > maxx) maxx = x2;
                    miny = y0; if (y1 < miny) miny = y1; if (y2 < miny) miny = y2;
                    maxy = y0; if (y1 > maxy) maxy = y1; if (y2 > maxy) maxy = y2;
                    minx = floor_div256(minx); maxx = ceil_div256(maxx);
                    miny = floor_div256(miny); maxy = ceil_div256(maxy);
                    if (minx < 0) minx = 0;
                    if (miny < 0) miny = 0;
                    if (maxx > W - 1) maxx = W - 1;
                    if (maxy > H - 1) maxy = H - 1;
                    for (longint y = miny; y <= maxy; y++)
                        for (longint x = minx; x <= maxx; x++)
                        begin
                            px = x * 256 + 128;
                            py = y * 256 + 128;
                            e0 = edge_val(x1, y1, x2, y2, px, py);
                            e1 = edge_val(x2, y2, x0, y0, px, py);
                            e2 = edge_val(x0, y0, x1, y1, px, py);
                            if (area > 0 && (e0 < 0 || e1 < 0 || e2 < 0)) continue;
                            if (area < 0 && (e0 > 0 || e1 > 0 || e2 > 0)) continue;
                            z = (d0 * e0 + d1 * e1 + d2 * e2) / area;
                            biased = 17'(z + 32768);
                            if (biased < shadow_map[y * W + x])
                            begin
                                shadow_map[y * W + x] = biased;
                                cnt++;
                            end
                        end
                    r.pixels_written = 17'(cnt);
                end
            end
            sdr_pkg::MODE_SAMPLE:
            begin
                if (it.sample_x >= 0 && it.sample_y >= 0 && it.sample_x < W && it.sample_y < H)
                begin
                    r.read_depth = shadow_map[int'(it.sample_y) * W + int'(it.sample_x)];
                    r.in_map = 1'b1;
                end
                else
                    r.read_depth = sdr_pkg::DEPTH_EMPTY;
            end
            sdr_pkg::MODE_CLEAR:
                foreach (shadow_map[i]) shadow_map[i] = sdr_pkg::DEPTH_EMPTY;
            default: ;
        endcase
        return r;
    endfunction

    function automatic sdr_pkg::in_item_t tri_item(int ax, int ay, int bx, int by,
                                                   int cx, int cy, int da, int db, int dc);
        sdr_pkg::in_item_t it;
        it = '0;
        it.mode = sdr_pkg::MODE_DRAW;
        it.v0_x = 20'(ax); it.v0_y = 20'(ay); it.v0_depth = 16'(da);
        it.v1_x = 20'(bx); it.v1_y = 20'(by); it.v1_depth = 16'(db);
        it.v2_x = 20'(cx); it.v2_y = 20'(cy); it.v2_depth = 16'(dc);
        return it;
    endfunction

    function automatic sdr_pkg::in_item_t sample_item(int sx, int sy);
        sdr_pkg::in_item_t it;
        it = '0;
        it.mode = sdr_pkg::MODE_SAMPLE;
        it.sample_x = 12'(sx);
        it.sample_y = 12'(sy);
        return it;
    endfunction

    function automatic sdr_pkg::in_item_t random_item();
        sdr_pkg::in_item_t it;
        int pick, cx, cy, span;
        it = sdr_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                  2'($urandom)});
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // mostly small triangles near or on the map so draws stay short
            span = ($urandom_range(0, 9) == 0) ? 6000 : 1500;
            cx = $urandom_range(0, 70000) - 3000;
            cy = $urandom_range(0, 70000) - 3000;
            it = tri_item(cx + $urandom_range(0, 2 * span) - span,
                          cy + $urandom_range(0, 2 * span) - span,
                          cx + $urandom_range(0, 2 * span) - span,
                          cy + $urandom_range(0, 2 * span) - span,
                          cx + $urandom_range(0, 2 * span) - span,
                          cy + $urandom_range(0, 2 * span) - span,
                          $urandom_range(0, 65535) - 32768,
                          $urandom_range(0, 65535) - 32768,
                          $urandom_range(0, 65535) - 32768);
            if ($urandom_range(0, 19) == 0)
            begin
                it.v2_x = it.v1_x;
                it.v2_y = it.v1_y;
            end
        end
        else if (pick < 60)
        begin
            // wild vertices far off the map, bounding box clamps away
            it.mode = sdr_pkg::MODE_DRAW;
            if (it.v0_x < 0 || it.v1_x < 0 || it.v2_x < 0)
            begin
                it.v0_x[19] = 1'b1; it.v1_x[19] = 1'b1; it.v2_x[19] = 1'b1;
            end
            else
            begin
                it.v0_x[18] = 1'b1; it.v1_x[18] = 1'b1; it.v2_x[18] = 1'b1;
            end
        end
        else if (pick < 93)
        begin
            it.mode = sdr_pkg::MODE_SAMPLE;
            if ($urandom_range(0, 5) != 0)
            begin
                it.sample_x = 12'($urandom_range(0, W - 1));
                it.sample_y = 12'($urandom_range(0, H - 1));
            end
        end
        else if (pick < 96)
            it.mode = MODE_NOP;
        else
            it.mode = sdr_pkg::MODE_CLEAR;
        return it;
    endfunction

    task automatic push_item(sdr_pkg::in_item_t it);
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_and_expect(sdr_pkg::in_item_t it);
        pending_results.push_back(rasterize_item(it));
        push_item(it);
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // receiver stall pattern
    initial
    begin
        int mode_sel;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode_sel = $urandom_range(0, 2);
            repeat ($urandom_range(10, 200))
            begin
                @(posedge clk);
                out_stall <= (mode_sel == 0) ? 1'b0 :
                             (mode_sel == 1) ? ($urandom_range(0, 3) == 0) :
                             ($urandom_range(0, 1) == 0);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        sdr_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.read_depth !== want.read_depth)
                begin
                    $error("read_depth: expected %0d actual %0d", want.read_depth,
                           out_item.read_depth);
                    errors++;
                end
                if (out_item.in_map !== want.in_map)
                begin
                    $error("in_map: expected %0d actual %0d", want.in_map, out_item.in_map);
                    errors++;
                end
                if (out_item.pixels_written !== want.pixels_written)
                begin
                    $error("pixels_written: expected %0d actual %0d", want.pixels_written,
                           out_item.pixels_written);
                    errors++;
                end
                if (out_item.degenerate !== want.degenerate)
                begin
                    $error("degenerate: expected %0d actual %0d", want.degenerate,
                           out_item.degenerate);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer; limit covers the clearing pass after reset
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        sdr_pkg::out_item_t want;
        sdr_pkg::in_item_t it;
        dir_row_t row;
        int burst;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        foreach (shadow_map[i]) shadow_map[i] = sdr_pkg::DEPTH_EMPTY;

        // directed table: known results typed in where obvious
        row.has_known = 1;
        row.item = sample_item(0, 0);
        row.known = '{read_depth: sdr_pkg::DEPTH_EMPTY, in_map: 1'b1, pixels_written: 0,
                      degenerate: 0};
        dir_rows.push_back(row);
        row.item = sample_item(-2048, 2047);
        row.known = '{read_depth: sdr_pkg::DEPTH_EMPTY, in_map: 1'b0, pixels_written: 0,
                      degenerate: 0};
        dir_rows.push_back(row);
        row.item = sample_item(256, 5);
        dir_rows.push_back(row);
        row.item = tri_item(100, 100, 100, 100, 3000, 4000, 5, 6, 7);
        row.known = '{read_depth: 0, in_map: 0, pixels_written: 0, degenerate: 1'b1};
        dir_rows.push_back(row);
        row.item = tri_item(-524288, -524288, -524288, -524288, 524287, 524287, 0, 0, 0);
        dir_rows.push_back(row);
        row.item = '1;
        row.item.mode = MODE_NOP;
        row.known = '0;
        dir_rows.push_back(row);
        row.item = '0;
        row.item.mode = sdr_pkg::MODE_CLEAR;
        dir_rows.push_back(row);
        row.item = tri_item(-524288, -524288, -524200, -524288, -524288, -524000, 1, 2, 3);
        row.known = '0;
        dir_rows.push_back(row);
        row.has_known = 0;
        dir_rows.push_back('{tri_item(0, 0, 2560, 0, 0, 2560, -32768, 32767, 0), 0, '0});
        dir_rows.push_back('{tri_item(0, 0, 0, 2560, 2560, 0, 32767, -32768, -32768), 0, '0});
        dir_rows.push_back('{tri_item(512, 512, 1024, 512, 512, 1024, -32768, -32768,
                                     -32768), 0, '0});
        dir_rows.push_back('{tri_item(64000, 64000, 66000, 65000, 65000, 67000, 100, 200,
                                     300), 0, '0});
        dir_rows.push_back('{tri_item(-600, -600, 1500, -300, 200, 1800, 10, -10, 0), 0, '0});
        dir_rows.push_back('{sample_item(0, 0), 0, '0});
        dir_rows.push_back('{sample_item(2, 2), 0, '0});
        dir_rows.push_back('{sample_item(255, 255), 0, '0});
        dir_rows.push_back('{sample_item(1, 0), 0, '0});
        dir_rows.push_back('{sample_item(2047, -1), 0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            want = rasterize_item(dir_rows[i].item);
            if (dir_rows[i].has_known && want !== dir_rows[i].known)
            begin
                $error("directed row %0d: table disagrees with prediction", i);
                errors++;
            end
            pending_results.push_back(want);
            push_item(dir_rows[i].item);
            maybe_gap();
        end

        for (int n = 0; n < 580; )
        begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < 580; b++, n++)
            begin
                it = random_item();
                send_and_expect(it);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/sdr_pkg.sv
src/sdr_ram.sv
src/sdr_mac.sv
src/sdr_div.sv
src/shadow_depth_rasterizer.sv
tb/shadow_depth_rasterizer_tb.sv
